// ===== hdl/spl_pkg.sv =====
// Shared types and constants for the sorted point list block.
package spl_pkg;

	// Result status codes
	localparam logic [1:0] STAT_INSERTED = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_DUMP     = 2'd2;
	localparam logic [1:0] STAT_EMPTY    = 2'd3;

	// Input command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DUMP   = 1'b1;

	// Distance arithmetic: 3 squares, then a 50-bit operand, 2 bits per root step
	localparam int unsigned AXES      = 3;
	localparam int unsigned SQ_W      = 34;
	localparam int unsigned FRAC_W    = 16;
	localparam int unsigned OP_W      = SQ_W + FRAC_W;
	localparam int unsigned ROOT_W    = OP_W / 2;
	localparam int unsigned STEP_W    = 5;
	localparam int unsigned PATH_W    = 40;
	localparam int unsigned COUNT_OUT_W = 6;

	typedef struct packed {
		logic [15:0] z;
		logic [15:0] y;
		logic [15:0] x;
	} coord_t;

	typedef struct packed {
		logic [31:0] key;
		coord_t      pt;
	} entry_t;

	// Distance unit status toward the sequencer
	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] span;
	} dist_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WCMP,
		ST_WPUT,
		ST_FIN,
		ST_DRD,
		ST_DLD,
		ST_OUT
	} top_st_t;

	typedef enum logic [1:0] {
		DS_IDLE,
		DS_MUL,
		DS_ROOT
	} dist_st_t;

endpackage

// ===== hdl/spl_ram.sv =====
// Generic simple dual-port RAM with registered read.
module spl_ram #(
	parameter int unsigned WIDTH = 80,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/spl_dist.sv =====
// Euclidean distance unit: one shared multiplier for the squares, then a bit-serial root.
module spl_dist (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  spl_pkg::coord_t     cur,
	input  spl_pkg::coord_t     prev,
	output spl_pkg::dist_res_t  res
);

	spl_pkg::dist_st_t st_q, st_d;

	logic [spl_pkg::STEP_W-1:0] cnt_q;
	spl_pkg::coord_t            a_q, b_q;
	logic [spl_pkg::SQ_W-1:0]   acc_q;
	logic [spl_pkg::OP_W-1:0]   op_q;
	logic [spl_pkg::ROOT_W-1:0] rem_q;
	logic [spl_pkg::ROOT_W-1:0] root_q;
	logic                       done_q;

	logic [15:0]                ax, bx;
	logic [16:0]                diff;
	logic [15:0]                mag;
	logic [31:0]                prod;
	logic [spl_pkg::SQ_W-1:0]   acc_nxt;
	logic [spl_pkg::ROOT_W+1:0] rem_sh, trial;
	logic                       ge;
	logic                       mul_last, root_last;

	// axis select and |a - b|^2
	always_comb begin
		unique case (cnt_q[1:0])
			2'd0:    begin ax = a_q.x; bx = b_q.x; end
			2'd1:    begin ax = a_q.y; bx = b_q.y; end
			default: begin ax = a_q.z; bx = b_q.z; end
		endcase
		diff    = {ax[15], ax} - {bx[15], bx};
		mag     = diff[16] ? 16'(-diff) : diff[15:0];
		prod    = mag * mag;
		acc_nxt = acc_q + spl_pkg::SQ_W'(prod);
	end

	// one root digit: bring in two operand bits, trial subtract
	always_comb begin
		rem_sh = {rem_q, op_q[spl_pkg::OP_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		ge     = (rem_sh >= trial);
	end

	assign mul_last  = (cnt_q == spl_pkg::STEP_W'(spl_pkg::AXES - 1));
	assign root_last = (cnt_q == spl_pkg::STEP_W'(spl_pkg::ROOT_W - 1));

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			spl_pkg::DS_IDLE: if (start) st_d = spl_pkg::DS_MUL;
			spl_pkg::DS_MUL:  if (mul_last) st_d = spl_pkg::DS_ROOT;
			spl_pkg::DS_ROOT: if (root_last) st_d = spl_pkg::DS_IDLE;
			default:          st_d = spl_pkg::DS_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= spl_pkg::DS_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == spl_pkg::DS_ROOT) && root_last;
			if (st_q == spl_pkg::DS_IDLE || (st_q == spl_pkg::DS_MUL && mul_last)) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			spl_pkg::DS_IDLE: begin
				if (start) begin
					a_q   <= cur;
					b_q   <= prev;
					acc_q <= '0;
				end
			end
			spl_pkg::DS_MUL: begin
				acc_q <= acc_nxt;
				if (mul_last) begin
					op_q   <= {acc_nxt, {spl_pkg::FRAC_W{1'b0}}};
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			spl_pkg::DS_ROOT: begin
				rem_q  <= ge ? spl_pkg::ROOT_W'(rem_sh - trial) : spl_pkg::ROOT_W'(rem_sh);
				root_q <= {root_q[spl_pkg::ROOT_W-2:0], ge};
				op_q   <= {op_q[spl_pkg::OP_W-3:0], 2'b00};
			end
			default: ;
		endcase
	end

	assign res.done = done_q;
	assign res.span = root_q;

endmodule

// ===== hdl/sorted_point_list_with_path_length.sv =====
// Top level: sorted point table with insert/dump sequencer and path length accumulator.
//
// Holds up to DEPTH points sorted ascending by key (new point goes before equal keys) and
// a saturating arrival-order path length with 8 fraction bits. One word is taken at a time.
// An insert runs the distance unit (3 multiply steps, then 25 root steps, then a registered
// done flag that folds the root into the path length) alongside the table walk (one entry
// per cycle from the top down); the result word follows whichever ends later. The first
// point into an empty table skips the distance. Each dump entry passes through RAM read,
// load and output in that order. A rejected insert or an empty dump goes straight from
// idle to the result word. No clearing pass after reset.
module sorted_point_list_with_path_length #(
	parameter int unsigned DEPTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [79:0]  s_tdata,   // point_x, point_y, point_z, sort_key
	input  logic [0:0]   s_tuser,   // cmd
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // entry_count, path_length, entry_key, entry_x,
	                                // entry_y, entry_z, 2 zero bits
	output logic [1:0]   m_tuser,   // status
	output logic         m_tlast
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	spl_pkg::top_st_t st_q, st_d;

	logic [CW-1:0]              count_q;
	spl_pkg::coord_t            prev_q;
	logic [spl_pkg::PATH_W-1:0] len_q;
	spl_pkg::entry_t            new_q;
	logic [AW-1:0]              i_q;
	logic [AW-1:0]              idx_q;
	logic                       dbusy_q;

	logic [1:0]                      out_stat_q;
	logic [spl_pkg::COUNT_OUT_W-1:0] out_cnt_q;
	logic [spl_pkg::PATH_W-1:0]      out_len_q;
	spl_pkg::entry_t                 out_ent_q;
	logic                            out_last_q;

	spl_pkg::entry_t    in_ent, rd_ent, wr_ent;
	logic               in_cmd;
	logic               accept, full, empty, shift, dist_start;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic               dump_last, fin_go;
	spl_pkg::dist_res_t dres;
	logic [spl_pkg::PATH_W:0] len_sum;

	assign in_ent.pt.x = s_tdata[15:0];
	assign in_ent.pt.y = s_tdata[31:16];
	assign in_ent.pt.z = s_tdata[47:32];
	assign in_ent.key  = s_tdata[79:48];
	assign in_cmd      = s_tuser[0];

	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign shift     = (new_q.key <= rd_ent.key);
	assign dump_last = (idx_q == AW'(count_q - 1'b1));
	assign fin_go    = !dbusy_q;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			spl_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (in_cmd == spl_pkg::CMD_DUMP) begin
						st_d = empty ? spl_pkg::ST_OUT : spl_pkg::ST_DRD;
					end else if (full) begin
						st_d = spl_pkg::ST_OUT;
					end else begin
						st_d = empty ? spl_pkg::ST_WPUT : spl_pkg::ST_WCMP;
					end
				end
			end
			spl_pkg::ST_WCMP: begin
				if (!shift) begin
					st_d = spl_pkg::ST_FIN;
				end else if (i_q == AW'(1)) begin
					st_d = spl_pkg::ST_WPUT;
				end
			end
			spl_pkg::ST_WPUT: st_d = spl_pkg::ST_FIN;
			spl_pkg::ST_FIN:  if (fin_go) st_d = spl_pkg::ST_OUT;
			spl_pkg::ST_DRD:  st_d = spl_pkg::ST_DLD;
			spl_pkg::ST_DLD:  st_d = spl_pkg::ST_OUT;
			spl_pkg::ST_OUT: begin
				if (m_tready) begin
					st_d = out_last_q ? spl_pkg::ST_IDLE : spl_pkg::ST_DRD;
				end
			end
			default: st_d = spl_pkg::ST_IDLE;
		endcase
	end

	// state outputs: handshake, RAM ports, distance start
	always_comb begin
		s_tready   = (st_q == spl_pkg::ST_IDLE);
		m_tvalid   = (st_q == spl_pkg::ST_OUT);
		accept     = s_tvalid && s_tready;
		dist_start = accept && (in_cmd == spl_pkg::CMD_INSERT) && !full && !empty;
		ram_we     = 1'b0;
		ram_waddr  = i_q;
		wr_ent     = new_q;
		ram_raddr  = '0;
		unique case (st_q)
			spl_pkg::ST_IDLE: ram_raddr = AW'(count_q - 1'b1);
			spl_pkg::ST_WCMP: begin
				ram_we    = 1'b1;
				wr_ent    = shift ? rd_ent : new_q;
				ram_raddr = AW'(i_q - 2'd2);
			end
			spl_pkg::ST_WPUT: ram_we = 1'b1;
			spl_pkg::ST_DRD:  ram_raddr = idx_q;
			default: ;
		endcase
	end

	spl_ram #(
		.WIDTH ($bits(spl_pkg::entry_t)),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_ent),
		.raddr (ram_raddr),
		.rdata (rd_ent)
	);

	spl_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dist_start),
		.cur    (in_ent.pt),
		.prev   (prev_q),
		.res    (dres)
	);

	assign len_sum = {1'b0, len_q} + (spl_pkg::PATH_W + 1)'(dres.span);

	// control and table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= spl_pkg::ST_IDLE;
			count_q <= '0;
			prev_q  <= '0;
			len_q   <= '0;
			dbusy_q <= 1'b0;
			i_q     <= '0;
			idx_q   <= '0;
		end else begin
			st_q <= st_d;
			if (dist_start) begin
				dbusy_q <= 1'b1;
			end else if (dres.done) begin
				dbusy_q <= 1'b0;
			end
			// saturating path length
			if (dres.done) begin
				len_q <= len_sum[spl_pkg::PATH_W] ? '1 : len_sum[spl_pkg::PATH_W-1:0];
			end
			if (accept) begin
				i_q   <= AW'(count_q);
				idx_q <= '0;
			end else if (st_q == spl_pkg::ST_WCMP && shift) begin
				i_q <= i_q - 1'b1;
			end
			if (st_q == spl_pkg::ST_OUT && m_tready && !out_last_q) begin
				idx_q <= idx_q + 1'b1;
			end
			if (st_q == spl_pkg::ST_FIN && fin_go) begin
				count_q <= count_q + 1'b1;
				prev_q  <= new_q.pt;
			end
		end
	end

	// result word and latched input point
	always_ff @(posedge clk) begin
		if (accept) begin
			new_q <= in_ent;
		end
		if (accept && (empty || full)) begin
			out_stat_q <= (in_cmd == spl_pkg::CMD_DUMP) ? spl_pkg::STAT_EMPTY
			                                            : spl_pkg::STAT_FULL;
			out_cnt_q  <= spl_pkg::COUNT_OUT_W'(count_q);
			out_len_q  <= len_q;
			out_ent_q  <= '0;
			out_last_q <= 1'b1;
		end else if (st_q == spl_pkg::ST_FIN && fin_go) begin
			out_stat_q <= spl_pkg::STAT_INSERTED;
			out_cnt_q  <= spl_pkg::COUNT_OUT_W'(count_q + 1'b1);
			out_len_q  <= len_q;
			out_ent_q  <= '0;
			out_last_q <= 1'b1;
		end else if (st_q == spl_pkg::ST_DLD) begin
			out_stat_q <= spl_pkg::STAT_DUMP;
			out_cnt_q  <= spl_pkg::COUNT_OUT_W'(count_q);
			out_len_q  <= len_q;
			out_ent_q  <= rd_ent;
			out_last_q <= dump_last;
		end
	end

	assign m_tdata = {2'b00, out_ent_q.pt.z, out_ent_q.pt.y, out_ent_q.pt.x,
	                  out_ent_q.key, out_len_q, out_cnt_q};
	assign m_tuser = out_stat_q;
	assign m_tlast = out_last_q;

endmodule

// ===== hdl/spl_chk.sv =====
// Port-level checker for the sorted point list, bound to the top level.
module spl_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic [1:0]   m_tuser,
	input logic         m_tlast
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// one word at a time: busy right after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on consecutive cycles");

	// no new word taken while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while result pending");

	// single-result statuses close their run and carry no entry
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == spl_pkg::STAT_INSERTED || m_tuser == spl_pkg::STAT_FULL ||
		m_tuser == spl_pkg::STAT_EMPTY) |-> m_tlast && (m_tdata[127:46] == '0))
		else $error("non-dump result malformed");

	// a dump run takes no new input word before its last word
	a_dump_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> !s_tready)
		else $error("dump run broken");

endmodule

bind sorted_point_list_with_path_length spl_chk u_spl_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
